>>> rtl/clt_pkg.sv
// Shared types, constants and helper functions for the core-local timer interruptor.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package clt_pkg;

  localparam logic [15:0] SOFT_OFFSET    = 16'd0;
  localparam logic [15:0] COMPARE_OFFSET = 16'd16384;
  localparam logic [15:0] TIME_OFFSET    = 16'd49144;
  localparam int unsigned TICKS_PER_MS   = 1000;

  localparam logic [16:0] SOFT_LEN    = 17'd4;
  localparam logic [16:0] COMPARE_LEN = 17'd8;
  localparam logic [16:0] TIME_LEN    = 17'd8;

  localparam logic [31:0] SOFT_RESET    = 32'h0000_0000;
  localparam logic [63:0] COMPARE_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TIME_RESET    = 64'h0000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] address;
    logic [3:0]  size_bytes;
    logic [63:0] write_data;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        timer_pending;
    logic        software_pending;
  } result_t;

  // Byte-lane mask for an access of n bytes; sizes of 8 and above cover all lanes.
  function automatic logic [63:0] lane_mask(input logic [3:0] n);
    logic [63:0] m;
    if (n == 4'd0) begin
      m = '0;
    end else if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic in_window(input logic [15:0] addr, input logic [15:0] base,
                                     input logic [16:0] len);
    return (addr >= base) && ({1'b0, addr} < ({1'b0, base} + len));
  endfunction

endpackage

>>> rtl/clt_if.sv
// Valid/ready channel interfaces for the interruptor's request and response beats.
// Depends on clt_pkg for the operation type.

interface clt_req_if;
  logic           valid;
  logic           ready;
  clt_pkg::op_t   operation;
  logic [15:0]    address;
  logic [3:0]     size_bytes;
  logic [63:0]    write_data;
  logic [63:0]    time_ms;

  modport source (output valid, operation, address, size_bytes, write_data, time_ms,
                  input ready);
  modport sink (input valid, operation, address, size_bytes, write_data, time_ms,
                output ready);
endinterface

interface clt_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        timer_pending;
  logic        software_pending;

  modport source (output valid, read_data, timer_pending, software_pending, input ready);
  modport sink (input valid, read_data, timer_pending, software_pending, output ready);
endinterface

>>> rtl/clt_regs.sv
// Register file of the interruptor: address decode, read alignment, byte-lane merge
// and pending-flag evaluation. Depends on clt_pkg.

module clt_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  clt_pkg::item_t   item,
  input  logic [63:0]      tick_time,
  output clt_pkg::result_t result
);

  logic [31:0] soft_word;
  logic [63:0] compare_value;
  logic [63:0] time_value;
  logic        timer_flag;
  logic        soft_flag;

  logic [31:0] soft_word_next;
  logic [63:0] compare_value_next;
  logic [63:0] time_value_next;
  logic        timer_flag_next;
  logic        soft_flag_next;

  logic        hit_soft;
  logic        hit_compare;
  logic        hit_time;
  logic [2:0]  lane;
  logic [5:0]  shift;
  logic [63:0] mask;
  logic [63:0] selected;
  logic [63:0] read_data;
  logic [63:0] soft_merged;
  logic [63:0] compare_merged;

  assign hit_soft    = clt_pkg::in_window(item.address, clt_pkg::SOFT_OFFSET,
                                          clt_pkg::SOFT_LEN);
  assign hit_compare = clt_pkg::in_window(item.address, clt_pkg::COMPARE_OFFSET,
                                          clt_pkg::COMPARE_LEN);
  assign hit_time    = clt_pkg::in_window(item.address, clt_pkg::TIME_OFFSET,
                                          clt_pkg::TIME_LEN);
  assign mask        = clt_pkg::lane_mask(item.size_bytes);

  // Overlapping windows resolve in favor of the software word, then compare, then time.
  always_comb begin
    lane     = '0;
    selected = '0;
    priority if (hit_soft) begin
      lane     = item.address[2:0] - clt_pkg::SOFT_OFFSET[2:0];
      selected = {32'd0, soft_word};
    end else if (hit_compare) begin
      lane     = item.address[2:0] - clt_pkg::COMPARE_OFFSET[2:0];
      selected = compare_value;
    end else if (hit_time) begin
      lane     = item.address[2:0] - clt_pkg::TIME_OFFSET[2:0];
      selected = time_value;
    end else begin
      lane     = '0;
      selected = '0;
    end
  end

  assign shift          = {lane, 3'b000};
  assign read_data      = (selected >> shift) & mask;
  // Full-width writes fall out of the merge, since the mask then covers the register.
  assign soft_merged    = ({32'd0, soft_word} & ~(mask << shift))
                        | ((item.write_data & mask) << shift);
  assign compare_merged = (compare_value & ~(mask << shift))
                        | ((item.write_data & mask) << shift);

  always_comb begin
    soft_word_next     = soft_word;
    compare_value_next = compare_value;
    time_value_next    = time_value;
    timer_flag_next    = timer_flag;
    soft_flag_next     = soft_flag;
    result.read_data   = '0;
    unique case (item.operation)
      clt_pkg::OP_READ: begin
        result.read_data = read_data;
      end
      clt_pkg::OP_WRITE: begin
        if (hit_soft) begin
          soft_word_next = soft_merged[31:0];
        end else if (hit_compare) begin
          compare_value_next = compare_merged;
        end
      end
      clt_pkg::OP_TICK: begin
        time_value_next = tick_time;
        timer_flag_next = (tick_time >= compare_value);
        soft_flag_next  = soft_word[0];
      end
      clt_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
    result.timer_pending    = timer_flag_next;
    result.software_pending = soft_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_word     <= clt_pkg::SOFT_RESET;
      compare_value <= clt_pkg::COMPARE_RESET;
      time_value    <= clt_pkg::TIME_RESET;
      timer_flag    <= 1'b0;
      soft_flag     <= 1'b0;
    end else if (fire) begin
      soft_word     <= soft_word_next;
      compare_value <= compare_value_next;
      time_value    <= time_value_next;
      timer_flag    <= timer_flag_next;
      soft_flag     <= soft_flag_next;
    end
  end

endmodule

>>> rtl/core_local_timer_interruptor_top.sv
// Top level of the single-hart core-local timer interruptor.
// Depends on clt_pkg, clt_if.sv (clt_req_if, clt_rsp_if) and clt_regs.
//
//   Channel  Modport  Beat carries
//   req      sink     operation, address, size_bytes, write_data, time_ms
//   rsp      source   read_data, timer_pending, software_pending
//
// Each request beat yields exactly one response beat, passed through the input register
// and then the response register. A new request can be taken every cycle while rsp is
// not stalled; this rate is set by the input and response registers, with the register
// update, 64-bit compare and read alignment in between. The tick scaling multiply is done
// as the request is captured. Reset clears the pipeline and loads the register reset
// values; a stalled response holds its register and backs up into the input register.

module core_local_timer_interruptor_top (
  input logic       clk,
  input logic       rst,
  clt_req_if.sink   req,
  clt_rsp_if.source rsp
);

  logic             stage_valid;
  clt_pkg::item_t   stage_item;
  logic [63:0]      stage_time;
  logic             out_valid;
  clt_pkg::result_t out_result;
  clt_pkg::result_t result;
  logic             advance;
  logic             take;

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;
  assign take      = req.valid && req.ready;

  clt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (stage_item),
    .tick_time (stage_time),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_item.operation  <= req.operation;
      stage_item.address    <= req.address;
      stage_item.size_bytes <= req.size_bytes;
      stage_item.write_data <= req.write_data;
      stage_time            <= req.time_ms * 64'(clt_pkg::TICKS_PER_MS);
    end
    if (advance) begin
      out_result <= result;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.read_data        = out_result.read_data;
  assign rsp.timer_pending    = out_result.timer_pending;
  assign rsp.software_pending = out_result.software_pending;

endmodule

>>> sim/clt_result_check.sv
// Response checker for the core-local timer interruptor: predicts every response beat from
// the request beats it sees and compares them in order. Depends on clt_pkg and clt_if.sv.
`timescale 1ns / 100ps

module clt_result_check (
  input  logic clk,
  input  logic rst,
  clt_req_if   req,
  clt_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);

  import clt_pkg::*;

  typedef enum logic [1:0] {
    WIN_SOFT,
    WIN_CMP,
    WIN_TIME,
    WIN_NONE
  } window_t;

  localparam int unsigned SOFT_BASE = SOFT_OFFSET;
  localparam int unsigned CMP_BASE  = COMPARE_OFFSET;
  localparam int unsigned TIME_BASE = TIME_OFFSET;

  // Shadow copy of the interruptor registers.
  logic [31:0] msip_word;
  logic [63:0] cmp_reg;
  logic [63:0] mtime_reg;
  logic        timer_flag;
  logic        soft_flag;

  result_t due_rsp[$];

  function automatic logic [63:0] bytes_enabled(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Applies one request beat to the shadow registers and returns the response it owes.
  function automatic result_t advance_clint(input op_t op, input logic [15:0] addr,
                                            input logic [3:0] n, input logic [63:0] wdata,
                                            input logic [63:0] ms);
    result_t     r;
    window_t     win;
    int unsigned a;
    logic [2:0]  lane;
    logic [63:0] mask;
    logic [63:0] word;
    logic [63:0] lane_bits;
    logic [63:0] lane_data;
    a = addr;
    mask = bytes_enabled(n);
    win = WIN_NONE;
    lane = '0;
    word = '0;
    r.read_data = '0;
    // Overlapping windows resolve in the order soft word, compare, time.
    if (a >= SOFT_BASE && a < SOFT_BASE + 4) begin
      win = WIN_SOFT;
      lane = 3'(a - SOFT_BASE);
    end else if (a >= CMP_BASE && a < CMP_BASE + 8) begin
      win = WIN_CMP;
      lane = 3'(a - CMP_BASE);
    end else if (a >= TIME_BASE && a < TIME_BASE + 8) begin
      win = WIN_TIME;
      lane = 3'(a - TIME_BASE);
    end
    lane_bits = mask << {lane, 3'b000};
    lane_data = (wdata & mask) << {lane, 3'b000};
    case (op)
      OP_READ: begin
        case (win)
          WIN_SOFT: word = {32'b0, msip_word};
          WIN_CMP:  word = cmp_reg;
          WIN_TIME: word = mtime_reg;
          default:  word = '0;
        endcase
        r.read_data = (word >> {lane, 3'b000}) & mask;
      end
      OP_WRITE: begin
        if (win == WIN_SOFT) begin
          word = ({32'b0, msip_word} & ~lane_bits) | lane_data;
          msip_word = word[31:0];
        end else if (win == WIN_CMP) begin
          cmp_reg = (cmp_reg & ~lane_bits) | lane_data;
        end
      end
      OP_TICK: begin
        mtime_reg = ms * 64'(TICKS_PER_MS);
        timer_flag = (mtime_reg >= cmp_reg);
        soft_flag = msip_word[0];
      end
      default: ;
    endcase
    r.timer_pending = timer_flag;
    r.software_pending = soft_flag;
    return r;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      msip_word = SOFT_RESET;
      cmp_reg = COMPARE_RESET;
      mtime_reg = TIME_RESET;
      timer_flag = 1'b0;
      soft_flag = 1'b0;
      due_rsp.delete();
    end else begin
      if (req.valid && req.ready) begin
        due_rsp.push_back(advance_clint(req.operation, req.address, req.size_bytes,
                                        req.write_data, req.time_ms));
      end
      if (rsp.valid && rsp.ready) begin
        if (due_rsp.size() == 0) begin
          errors++;
          $display("%0t: response beat with no request waiting, read_data %h", $time,
                   rsp.read_data);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                     rsp.read_data);
          end
          if (rsp.timer_pending !== want.timer_pending) begin
            errors++;
            $display("%0t: timer_pending expected %b, got %b", $time, want.timer_pending,
                     rsp.timer_pending);
          end
          if (rsp.software_pending !== want.software_pending) begin
            errors++;
            $display("%0t: software_pending expected %b, got %b", $time,
                     want.software_pending, rsp.software_pending);
          end
        end
      end
    end
    outstanding = due_rsp.size();
  end

endmodule

>>> sim/tb.sv
// Top of the interruptor testbench: clock, reset, request and response stimulus, watchdog
// and verdict. Depends on clt_pkg, clt_if.sv, the RTL top and clt_result_check.
`timescale 1ns / 100ps

module tb;

  import clt_pkg::*;

  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BEATS   = 1750;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;

  clt_req_if req ();
  clt_rsp_if rsp ();

  core_local_timer_interruptor_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  clt_result_check result_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  bit tx_gaps     = 1'b0;
  bit rx_steady   = 1'b0;
  int hold_asks   = 0;
  int hold_done   = 0;
  int hold_left   = 0;
  int beats_sent  = 0;
  int quiet_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Response side: random back-pressure, a steady stretch, or a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asks;
    end else if (rx_steady) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly addresses in or just around the three windows, sometimes anywhere.
  function automatic logic [15:0] pick_addr();
    logic [15:0] base;
    case ($urandom_range(9))
      0, 1, 2: base = SOFT_OFFSET;
      3, 4, 5: base = COMPARE_OFFSET;
      6, 7:    base = TIME_OFFSET;
      default: return 16'($urandom_range(65535));
    endcase
    return 16'(base + $urandom_range(9) - 1);
  endfunction

  function automatic logic [3:0] pick_size();
    case ($urandom_range(7))
      0, 1:    return 4'($urandom_range(15));
      2:       return 4'd1;
      3:       return 4'd2;
      4, 5:    return 4'd4;
      default: return 4'd8;
    endcase
  endfunction

  function automatic op_t pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return OP_READ;
    end else if (roll < 75) begin
      return OP_WRITE;
    end else if (roll < 95) begin
      return OP_TICK;
    end else begin
      return OP_NONE;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input op_t op, input logic [15:0] addr, input logic [3:0] n,
                           input logic [63:0] wdata, input logic [63:0] ms);
    // Each cycle idles on its own draw, so the idle share of cycles matches IDLE_PCT.
    if (tx_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.address    <= addr;
    req.size_bytes <= n;
    req.write_data <= wdata;
    req.time_ms    <= ms;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  task automatic run_random(input int upto);
    logic [63:0] cmp;
    logic [63:0] ms;
    while (beats_sent < upto) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          // Program compare, tick to just below, at or above it, then read both back.
          cmp = $urandom_range(1) ? rand64() : {32'b0, $urandom};
          ms = cmp / 64'(TICKS_PER_MS) + 64'($urandom_range(2)) - 64'd1;
          if ($urandom_range(1)) begin
            send_beat(OP_WRITE, COMPARE_OFFSET, 4'd8, cmp, rand64());
          end else begin
            send_beat(OP_WRITE, COMPARE_OFFSET + 16'd4, 4'd4, {32'b0, cmp[63:32]}, rand64());
            send_beat(OP_WRITE, COMPARE_OFFSET, 4'd4, {$urandom, cmp[31:0]}, rand64());
          end
          send_beat(OP_TICK, pick_addr(), pick_size(), rand64(), ms);
          send_beat(OP_READ, TIME_OFFSET + 16'($urandom_range(7)), pick_size(), rand64(),
                    rand64());
          send_beat(OP_READ, COMPARE_OFFSET + 16'($urandom_range(7)), pick_size(), rand64(),
                    rand64());
        end
        3, 4: begin
          send_beat(OP_WRITE, SOFT_OFFSET + 16'($urandom_range(3)), pick_size(), rand64(),
                    rand64());
          send_beat(OP_TICK, pick_addr(), pick_size(), rand64(), rand64());
          send_beat(OP_READ, SOFT_OFFSET + 16'($urandom_range(3)), pick_size(), rand64(),
                    rand64());
        end
        default: begin
          send_beat(pick_op(), pick_addr(), pick_size(), rand64(), rand64());
        end
      endcase
    end
  endtask

  initial begin
    int first_random;
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_READ;
    req.address = '0;
    req.size_bytes = '0;
    req.write_data = '0;
    req.time_ms = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values through every window.
    send_beat(OP_READ, SOFT_OFFSET, 4'd4, '0, '0);
    send_beat(OP_READ, COMPARE_OFFSET, 4'd8, '0, '0);
    send_beat(OP_READ, TIME_OFFSET, 4'd8, '0, '0);
    send_beat(OP_TICK, 16'd0, 4'd0, '0, 64'd0);
    // The software flag only follows the word at the next tick.
    send_beat(OP_WRITE, SOFT_OFFSET, 4'd4, '1, '0);
    send_beat(OP_READ, SOFT_OFFSET, 4'd8, '0, '0);
    send_beat(OP_TICK, 16'hFFFF, 4'd15, '1, 64'd5);
    // A write at the top byte of the soft word loses the lane above it.
    send_beat(OP_WRITE, SOFT_OFFSET + 16'd3, 4'd2, 64'h0000_0000_0000_5A00, '1);
    send_beat(OP_READ, SOFT_OFFSET + 16'd1, 4'd4, '0, '0);
    // Empty and oversized compare writes, then a tick landing exactly on compare.
    send_beat(OP_WRITE, COMPARE_OFFSET, 4'd0, 64'd0, '0);
    send_beat(OP_WRITE, COMPARE_OFFSET, 4'd15, 64'd5000, '0);
    send_beat(OP_TICK, SOFT_OFFSET, 4'd1, '0, 64'd5);
    send_beat(OP_WRITE, COMPARE_OFFSET + 16'd4, 4'd4, 64'hFFFF_FFFF, '0);
    send_beat(OP_READ, COMPARE_OFFSET + 16'd4, 4'd8, '0, '0);
    send_beat(OP_READ, COMPARE_OFFSET + 16'd7, 4'd0, '0, '0);
    // Time cannot be written from the bus.
    send_beat(OP_WRITE, TIME_OFFSET, 4'd8, '1, '0);
    send_beat(OP_READ, TIME_OFFSET, 4'd8, '0, '0);
    send_beat(OP_NONE, COMPARE_OFFSET, 4'd8, '1, '1);
    // The scaled tick value wraps around 64 bits.
    send_beat(OP_TICK, TIME_OFFSET, 4'd8, '0, '1);
    send_beat(OP_READ, TIME_OFFSET + 16'd7, 4'd1, '0, '0);
    send_beat(OP_READ, 16'hFFFF, 4'd8, '0, '0);
    send_beat(OP_READ, SOFT_OFFSET + 16'd4, 4'd8, '0, '0);
    send_beat(OP_READ, TIME_OFFSET + 16'd8, 4'd8, '0, '0);
    send_beat(OP_WRITE, SOFT_OFFSET, 4'd4, '0, '0);
    send_beat(OP_TICK, SOFT_OFFSET, 4'd4, '0, '0);
    wait_drained();

    first_random = beats_sent;
    tx_gaps = 1'b1;
    run_random(first_random + 500);

    // Response side stalls for a long time while requests keep coming.
    hold_asks <= hold_asks + 1;
    tx_gaps = 1'b0;
    run_random(beats_sent + 60);

    // No idling on either side.
    rx_steady <= 1'b1;
    run_random(beats_sent + 300);
    rx_steady <= 1'b0;
    tx_gaps = 1'b1;
    wait_drained();

    run_random(first_random + RANDOM_BEATS);
    req.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
